/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rdis_pkg.sv */
// Shared types and constants for the ReLU dot index scorer.
// No dependencies; used by controller, datapath, top level and checker.
package rdis_pkg;

    localparam int IDX_W   = 7;
    localparam int ELEM_W  = 16;
    localparam int SCORE_W = 32;
    localparam int ELEM_N  = 7;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_TOKEN  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam longint PROJ_MAX  = 64'sd32767;
    localparam longint PROJ_MIN  = -64'sd32768;
    localparam longint SCORE_MAX = 64'sd2147483647;
    localparam longint SCORE_MIN = -64'sd2147483648;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch the input beat
        logic load;       // write the latched weight
        logic issue;      // read one projection column
        logic key;        // column belongs to the key matrix
        logic first;      // first column of a head
        logic last_head;  // last column of a head
        logic last_col;   // last column of the item
        logic push;       // load the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic query_done;
        logic score_done;
    } status_t;

endpackage

/* rtl/rdis_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rdis_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rdis_ctrl.sv */
// Controller: sequences load, query and token items and owns the output valid.
// Depends on rdis_pkg.
module rdis_ctrl #(
    parameter int PROJ_LEN = 4,
    parameter int HEADS    = 2,
    localparam int NCOL  = HEADS * PROJ_LEN,
    localparam int COL_W = (NCOL > 1) ? $clog2(NCOL) : 1,
    localparam int H_W   = (HEADS > 1) ? $clog2(HEADS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    output logic              out_valid,
    input  logic              out_stall,
    output rdis_pkg::cmd_t    cmd,
    output logic [COL_W-1:0]  col,
    output logic [H_W-1:0]    head,
    input  rdis_pkg::status_t status
);

    localparam int J_W = (PROJ_LEN > 1) ? $clog2(PROJ_LEN) : 1;
    localparam logic [J_W-1:0]   J_LAST   = J_W'(PROJ_LEN - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(NCOL - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_RUN,
        S_DRAIN,
        S_PUSH
    } state_t;

    state_t           state_reg, state_next;
    logic             key_reg, key_next;
    logic [J_W-1:0]   j_reg, j_next;
    logic [H_W-1:0]   h_reg, h_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        j_next     = j_reg;
        h_next     = h_reg;
        col_next   = col_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                j_next   = '0;
                h_next   = '0;
                col_next = '0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (kind)
                        rdis_pkg::KIND_LOAD:
                        begin
                            state_next = S_LOAD;
                        end
                        rdis_pkg::KIND_QUERY:
                        begin
                            key_next   = 1'b0;
                            state_next = S_RUN;
                        end
                        rdis_pkg::KIND_TOKEN:
                        begin
                            key_next   = 1'b1;
                            state_next = S_RUN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_IDLE;
            end
            S_RUN:
            begin
                cmd.issue     = 1'b1;
                cmd.key       = key_reg;
                cmd.first     = (j_reg == '0);
                cmd.last_head = (j_reg == J_LAST);
                cmd.last_col  = (col_reg == COL_LAST);
                col_next      = col_reg + 1'b1;
                if (j_reg == J_LAST)
                begin
                    j_next = '0;
                    h_next = h_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
                if (col_reg == COL_LAST)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (key_reg && status.score_done)
                begin
                    state_next = S_PUSH;
                end
                else if (!key_reg && status.query_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_PUSH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = cmd.push | (out_valid_reg & out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_reg       <= 1'b0;
            j_reg         <= '0;
            h_reg         <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_reg       <= key_next;
            j_reg         <= j_next;
            h_reg         <= h_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign col       = col_reg;
    assign head      = h_reg;

endmodule

/* rtl/rdis_dp.sv */
// Datapath: banked weight store, column projection pipeline, dot/ReLU/score.
// Depends on rdis_pkg and rdis_ram.
module rdis_dp #(
    parameter int VEC_LEN  = 7,
    parameter int PROJ_LEN = 4,
    parameter int HEADS    = 2,
    localparam int NCOL  = HEADS * PROJ_LEN,
    localparam int COL_W = (NCOL > 1) ? $clog2(NCOL) : 1,
    localparam int H_W   = (HEADS > 1) ? $clog2(HEADS) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rdis_pkg::cmd_t                      cmd,
    input  logic [COL_W-1:0]                    col,
    input  logic [H_W-1:0]                      head,
    output rdis_pkg::status_t                   status,
    input  logic [rdis_pkg::IDX_W-1:0]          weight_index,
    input  logic signed [rdis_pkg::ELEM_W-1:0]  weight_value,
    input  logic signed [rdis_pkg::ELEM_W-1:0]  elem_0,
    input  logic signed [rdis_pkg::ELEM_W-1:0]  elem_1,
    input  logic signed [rdis_pkg::ELEM_W-1:0]  elem_2,
    input  logic signed [rdis_pkg::ELEM_W-1:0]  elem_3,
    input  logic signed [rdis_pkg::ELEM_W-1:0]  elem_4,
    input  logic signed [rdis_pkg::ELEM_W-1:0]  elem_5,
    input  logic signed [rdis_pkg::ELEM_W-1:0]  elem_6,
    input  logic                                last_token,
    output logic signed [rdis_pkg::SCORE_W-1:0] score,
    output logic                                last_score
);

    localparam int EW     = rdis_pkg::ELEM_W;
    localparam int SW     = rdis_pkg::SCORE_W;
    localparam int PW     = 2 * EW;
    localparam int IDX_N  = 2 ** rdis_pkg::IDX_W;
    localparam int BDEP   = 2 * NCOL;
    localparam int BA_W   = (BDEP > 1) ? $clog2(BDEP) : 1;
    localparam int L_W    = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;
    localparam int MW     = 2 + L_W + BA_W;
    localparam int SUM_W  = PW + $clog2(VEC_LEN);
    localparam int SH_W   = SUM_W - 15;
    localparam int DOT_W  = PW + $clog2(PROJ_LEN);
    localparam int HP_W   = DOT_W + EW;
    localparam int TERM_W = HP_W - 15;
    localparam int TOT_W  = TERM_W + $clog2(HEADS);

    // Weight index -> {valid, head weight, lane, bank address}. Lane is the
    // vector element, the bank address is matrix*NCOL + head*PROJ_LEN + column.
    function automatic logic [IDX_N*MW-1:0] build_map();
        logic [IDX_N*MW-1:0] m;
        int                  idx;
        m   = '0;
        idx = 0;
        for (int mt = 0; mt < 2; mt++)
        begin
            for (int hh = 0; hh < HEADS; hh++)
            begin
                for (int ll = 0; ll < VEC_LEN; ll++)
                begin
                    for (int jj = 0; jj < PROJ_LEN; jj++)
                    begin
                        if (idx < IDX_N)
                        begin
                            m[idx*MW +: MW] = {1'b1, 1'b0, L_W'(ll),
                                               BA_W'(mt * NCOL + hh * PROJ_LEN + jj)};
                        end
                        idx++;
                    end
                end
            end
        end
        for (int hh = 0; hh < HEADS; hh++)
        begin
            if (idx < IDX_N)
            begin
                m[idx*MW +: MW] = {1'b1, 1'b1, L_W'(0), BA_W'(hh)};
            end
            idx++;
        end
        return m;
    endfunction

    localparam logic [IDX_N*MW-1:0] LMAP = build_map();

    typedef struct packed {
        logic             v;
        logic             key;
        logic             first;
        logic             last_head;
        logic             last_col;
        logic [COL_W-1:0] col;
        logic [H_W-1:0]   h;
    } tag_t;

    // latched input beat
    logic [rdis_pkg::IDX_W-1:0] idx_reg;
    logic signed [EW-1:0]       value_reg;
    logic signed [EW-1:0]       vec_reg [VEC_LEN];
    logic                       last_reg;
    logic signed [EW-1:0]       elem_in [rdis_pkg::ELEM_N];

    // load decode
    logic [MW-1:0]   ent;
    logic            ent_valid;
    logic            ent_hw;
    logic [L_W-1:0]  ent_lane;
    logic [BA_W-1:0] ent_addr;
    logic [VEC_LEN-1:0] bank_we;
    logic [BA_W-1:0] rd_addr;
    logic [EW-1:0]   bank_rd [VEC_LEN];

    logic signed [EW-1:0] hw_reg [HEADS];
    logic signed [EW-1:0] qp_reg [NCOL];

    tag_t issue_tag;
    tag_t t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg;
    tag_t t4_next, t5_next;
    logic done_reg;

    logic signed [PW-1:0]     prod_reg [VEC_LEN];
    logic signed [SUM_W-1:0]  sum_next, sum_reg;
    logic signed [SH_W-1:0]   sh;
    logic signed [EW-1:0]     proj;
    logic signed [PW-1:0]     qk_reg;
    logic signed [DOT_W-1:0]  dot_next, dot_acc_reg, head_dot_reg, relu;
    logic signed [HP_W-1:0]   hprod_reg;
    logic signed [TERM_W-1:0] term;
    logic signed [TOT_W-1:0]  total_reg;
    logic signed [SW-1:0]     score_reg;
    logic                     last_score_reg;

    assign elem_in = '{elem_0, elem_1, elem_2, elem_3, elem_4, elem_5, elem_6};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg   <= weight_index;
            value_reg <= weight_value;
            last_reg  <= last_token;
            for (int l = 0; l < VEC_LEN; l++)
            begin
                vec_reg[l] <= elem_in[l];
            end
        end
    end

    assign ent       = LMAP[idx_reg*MW +: MW];
    assign ent_valid = ent[MW-1];
    assign ent_hw    = ent[MW-2];
    assign ent_lane  = ent[BA_W +: L_W];
    assign ent_addr  = ent[BA_W-1:0];

    always_comb
    begin
        rd_addr = cmd.key ? BA_W'(NCOL) + BA_W'(col) : BA_W'(col);
    end

    generate
        for (genvar l = 0; l < VEC_LEN; l++)
        begin : g_bank
            assign bank_we[l] = cmd.load & ent_valid & ~ent_hw & (ent_lane == L_W'(l));

            rdis_ram #(
                .WIDTH(EW),
                .DEPTH(BDEP)
            ) u_bank (
                .clk   (clk),
                .we    (bank_we[l]),
                .waddr (ent_addr),
                .wdata (value_reg),
                .raddr (rd_addr),
                .rdata (bank_rd[l])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.load && ent_valid && ent_hw)
        begin
            hw_reg[ent_addr[H_W-1:0]] <= value_reg;
        end
    end

    always_comb
    begin
        issue_tag.v         = cmd.issue;
        issue_tag.key       = cmd.key;
        issue_tag.first     = cmd.first;
        issue_tag.last_head = cmd.last_head;
        issue_tag.last_col  = cmd.last_col;
        issue_tag.col       = col;
        issue_tag.h         = head;
    end

    // dot stage only runs for key columns, head term only on a head's last column
    always_comb
    begin
        t4_next   = t3_reg;
        t4_next.v = t3_reg.v & t3_reg.key;
        t5_next   = t4_reg;
        t5_next.v = t4_reg.v & t4_reg.last_head;
    end

    // projection: product per lane, then column sum, then floor shift and clamp
    always_comb
    begin
        sum_next = '0;
        for (int l = 0; l < VEC_LEN; l++)
        begin
            sum_next = sum_next + SUM_W'(prod_reg[l]);
        end
    end

    assign sh = sum_reg[SUM_W-1:15];

    always_comb
    begin
        if (sh > SH_W'(rdis_pkg::PROJ_MAX))
        begin
            proj = EW'(rdis_pkg::PROJ_MAX);
        end
        else if (sh < SH_W'(rdis_pkg::PROJ_MIN))
        begin
            proj = EW'(rdis_pkg::PROJ_MIN);
        end
        else
        begin
            proj = sh[EW-1:0];
        end
    end

    assign dot_next = (t4_reg.first ? '0 : dot_acc_reg) + DOT_W'(qk_reg);
    assign relu     = head_dot_reg[DOT_W-1] ? '0 : head_dot_reg;
    assign term     = hprod_reg[HP_W-1:15];

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < VEC_LEN; l++)
        begin
            prod_reg[l] <= vec_reg[l] * $signed(bank_rd[l]);
        end
        sum_reg      <= sum_next;
        qk_reg       <= proj * qp_reg[t3_reg.col];
        head_dot_reg <= dot_next;
        if (t4_reg.v)
        begin
            dot_acc_reg <= dot_next;
        end
        hprod_reg <= relu * hw_reg[t5_reg.h];
        if (t6_reg.v)
        begin
            total_reg <= (t6_reg.h == '0 ? '0 : total_reg) + TOT_W'(term);
        end
        if (cmd.push)
        begin
            last_score_reg <= last_reg;
            if (total_reg > TOT_W'(rdis_pkg::SCORE_MAX))
            begin
                score_reg <= SW'(rdis_pkg::SCORE_MAX);
            end
            else if (total_reg < TOT_W'(rdis_pkg::SCORE_MIN))
            begin
                score_reg <= SW'(rdis_pkg::SCORE_MIN);
            end
            else
            begin
                score_reg <= total_reg[SW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg   <= '0;
            t2_reg   <= '0;
            t3_reg   <= '0;
            t4_reg   <= '0;
            t5_reg   <= '0;
            t6_reg   <= '0;
            done_reg <= 1'b0;
            for (int i = 0; i < NCOL; i++)
            begin
                qp_reg[i] <= '0;
            end
        end
        else
        begin
            t1_reg   <= issue_tag;
            t2_reg   <= t1_reg;
            t3_reg   <= t2_reg;
            t4_reg   <= t4_next;
            t5_reg   <= t5_next;
            t6_reg   <= t5_reg;
            done_reg <= t6_reg.v & t6_reg.last_col;
            if (t3_reg.v && !t3_reg.key)
            begin
                qp_reg[t3_reg.col] <= proj;
            end
        end
    end

    assign status.query_done = t3_reg.v & ~t3_reg.key & t3_reg.last_col;
    assign status.score_done = done_reg;
    assign score             = score_reg;
    assign last_score        = last_score_reg;

endmodule

/* rtl/relu_dot_index_scorer.sv */
// Load item: latch the beat, then write the weight. Query and token items issue
// HEADS*PROJ_LEN projection columns, one projection column per cycle through
// VEC_LEN multipliers; a token item then runs a dot/ReLU/score tail.
// One item in flight; the output register lets the next item start while a
// score waits. Async active-low reset clears control and the query vector;
// the weight store is undefined until loaded.
module relu_dot_index_scorer #(
    parameter int VEC_LEN  = 7,
    parameter int PROJ_LEN = 4,
    parameter int HEADS    = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          kind,
    input  logic [rdis_pkg::IDX_W-1:0]          weight_index,
    input  logic signed [rdis_pkg::ELEM_W-1:0]  weight_value,
    input  logic signed [rdis_pkg::ELEM_W-1:0]  elem_0,
    input  logic signed [rdis_pkg::ELEM_W-1:0]  elem_1,
    input  logic signed [rdis_pkg::ELEM_W-1:0]  elem_2,
    input  logic signed [rdis_pkg::ELEM_W-1:0]  elem_3,
    input  logic signed [rdis_pkg::ELEM_W-1:0]  elem_4,
    input  logic signed [rdis_pkg::ELEM_W-1:0]  elem_5,
    input  logic signed [rdis_pkg::ELEM_W-1:0]  elem_6,
    input  logic                                last_token,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rdis_pkg::SCORE_W-1:0] score,
    output logic                                last_score
);

    localparam int NCOL  = HEADS * PROJ_LEN;
    localparam int COL_W = (NCOL > 1) ? $clog2(NCOL) : 1;
    localparam int H_W   = (HEADS > 1) ? $clog2(HEADS) : 1;

    rdis_pkg::cmd_t    cmd;
    rdis_pkg::status_t status;
    logic [COL_W-1:0]  col;
    logic [H_W-1:0]    head;

    rdis_ctrl #(
        .PROJ_LEN(PROJ_LEN),
        .HEADS   (HEADS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .col       (col),
        .head      (head),
        .status    (status)
    );

    rdis_dp #(
        .VEC_LEN (VEC_LEN),
        .PROJ_LEN(PROJ_LEN),
        .HEADS   (HEADS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .col          (col),
        .head         (head),
        .status       (status),
        .weight_index (weight_index),
        .weight_value (weight_value),
        .elem_0       (elem_0),
        .elem_1       (elem_1),
        .elem_2       (elem_2),
        .elem_3       (elem_3),
        .elem_4       (elem_4),
        .elem_5       (elem_5),
        .elem_6       (elem_6),
        .last_token   (last_token),
        .score        (score),
        .last_score   (last_score)
    );

endmodule

/* rtl/rdis_checker.sv */
// Port-level checker for relu_dot_index_scorer, bound to the top level.
// Depends on rdis_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rdis_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic [1:0]                          kind,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [rdis_pkg::SCORE_W-1:0] score,
    input logic                                last_score
);

    logic in_beat;
    logic item_beat;
    logic unused_beat;
    logic out_held;

    assign in_beat     = in_valid && !in_stall;
    assign item_beat   = in_beat && (kind != rdis_pkg::KIND_UNUSED);
    assign unused_beat = in_beat && (kind == rdis_pkg::KIND_UNUSED);
    assign out_held    = out_valid && out_stall;

    // a held result keeps its payload
    `ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable({score, last_score}), "held beat moved")

    // any real item occupies the block for at least the next cycle
    `ASSERT_NEXT(a_busy_after_item, item_beat, in_stall, "input not held off after item")

    // unused kind is dropped without a busy cycle
    `ASSERT_NEXT(a_unused_kind, unused_beat, !in_stall, "unused kind stalled input")

    // a new result only comes out of a busy block
    `ASSERT_CLK(a_result_from_busy, !$rose(out_valid) || $past(in_stall), "result without work")

endmodule

bind relu_dot_index_scorer rdis_checker u_checker (.*);
